[rtl/mfp_pkg.sv]
package mfp_pkg;

  localparam int TIME_BITS_DEF   = 32;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] LEAD_LIMIT_RST      = 16'd10;
  localparam logic [CFG_W-1:0] MESSAGE_PENALTY_RST = 16'd2;
  localparam logic [CFG_W-1:0] BYTES_PER_TICK_RST  = 16'd120;
  localparam logic [CFG_W-1:0] MAX_LINE_RST        = 16'd510;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAD_LIMIT      = 2'd0,
    CFG_MESSAGE_PENALTY = 2'd1,
    CFG_BYTES_PER_TICK  = 2'd2,
    CFG_MAX_LINE_LENGTH = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_SENT      = 2'd0,
    ACT_DROPPED   = 2'd1,
    ACT_RESTARTED = 2'd2
  } action_t;

  // controller -> datapath, at most one step bit active per cycle
  typedef struct packed {
    logic capture;
    logic sum;
    logic cmp;
    logic send;
    logic check;
    logic div_init;
    logic div_step;
    logic add_pen;
    logic add_quo;
    logic res_wr;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic restart;
    logic drop;
    logic rate_zero;
    logic out_free;
  } sts_t;

endpackage

[rtl/message_flood_pacer_top.sv]
// Flood pacer: each message request (in_tuser = 0) is checked against an
// internal flood timer and answered with one result: sent with its release
// tick and possibly truncated length, or dropped when its deadline lies before
// the release tick; a restart request (in_tuser = 1) sets the timer to the
// given time. The byte penalty of a sent message is worked out by a
// bit-serial divider; a dropped message, a restart, and a message with a
// zero byte rate skip the divider. One request is worked on at a time; the
// next is taken as soon as the previous result is registered, even while
// that result still waits on out_tready.
// Configuration registers (cfg_index): 0 lead limit, 1 message penalty,
// 2 bytes per tick, 3 maximum line length; write them only while idle.
module message_flood_pacer_top import mfp_pkg::*; #(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int IN_W  = ((2 * TIME_BITS + LENGTH_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((TIME_BITS + LENGTH_BITS + 1 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // now_time, line_length, deadline
  input  logic                 in_tuser,   // req_type
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // send_time, sent_length, was_truncated
  output logic [1:0]           out_tuser   // action
);

  localparam int TB = TIME_BITS;
  localparam int LB = LENGTH_BITS;

  cmd_t          cmd;
  sts_t          sts;
  logic [TB-1:0] send_time;
  logic [LB-1:0] sent_length;
  logic          was_truncated;

  mfp_ctrl #(
    .LENGTH_BITS (LB)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfp_dp #(
    .TIME_BITS   (TB),
    .LENGTH_BITS (LB)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_req_type       (in_tuser),
    .in_now_time       (in_tdata[TB-1:0]),
    .in_line_length    (in_tdata[TB+LB-1:TB]),
    .in_deadline       (in_tdata[2*TB+LB-1:TB+LB]),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_tready),
    .out_valid         (out_tvalid),
    .out_action        (out_tuser),
    .out_send_time     (send_time),
    .out_sent_length   (sent_length),
    .out_was_truncated (was_truncated)
  );

  assign out_tdata = OUT_W'({was_truncated, sent_length, send_time});

endmodule

[rtl/mfp_ctrl.sv]
module mfp_ctrl import mfp_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_W = $clog2(LENGTH_BITS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SUM   = 10'b00_0000_0010,
    S_CMP   = 10'b00_0000_0100,
    S_SEND  = 10'b00_0000_1000,
    S_CHK   = 10'b00_0001_0000,
    S_DINIT = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_PEN   = 10'b00_1000_0000,
    S_QUO   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = sts.restart ? S_DONE : S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        cmd.send  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CNT_W'(LENGTH_BITS);
        priority if (sts.drop)      state_nxt = S_DONE;
        else if (sts.rate_zero)     state_nxt = S_PEN;
        else                        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) state_nxt = S_PEN;
      end
      S_PEN: begin
        cmd.add_pen = 1'b1;
        state_nxt   = S_QUO;
      end
      S_QUO: begin
        cmd.add_quo = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // wait here only while the previous result is still unclaimed
        cmd.res_wr = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_SUM))
    else $error("accepted request did not start evaluation");

  a_div_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !sts.rate_zero)
    else $error("divider running with zero byte rate");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r != '0))
    else $error("divider step count ran out");

endmodule

[rtl/mfp_dp.sv]
module mfp_dp import mfp_pkg::*; #(
  parameter int TIME_BITS   = TIME_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_req_type,
  input  logic [TIME_BITS-1:0]   in_now_time,
  input  logic [LENGTH_BITS-1:0] in_line_length,
  input  logic [TIME_BITS-1:0]   in_deadline,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_action,
  output logic [TIME_BITS-1:0]   out_send_time,
  output logic [LENGTH_BITS-1:0] out_sent_length,
  output logic                   out_was_truncated
);

  localparam int TB = TIME_BITS;
  localparam int LB = LENGTH_BITS;
  localparam int SW = ((TB > LB) ? TB : LB) + 1;
  localparam int CW = ((LB > CFG_W) ? LB : CFG_W);
  localparam logic [TB-1:0] TOP = {TB{1'b1}};

  logic [CFG_W-1:0] lead_r, pen_r, bpt_r, maxlen_r;

  logic          restart_r;
  logic [TB-1:0] now_r, dl_r, flood_r;
  logic [LB-1:0] len_r;
  logic [TB:0]   nl_r, fp_r;
  logic          hold_r;
  logic [TB-1:0] exc_r, send_r, base_r, t_r;
  logic          drop_r, cut_r;
  logic [LB-1:0] len_cut_r, quo_r;
  logic [CFG_W-1:0] rem_r;

  logic             res_valid_r;
  logic [1:0]       res_act_r;
  logic [TB-1:0]    res_send_r;
  logic [LB-1:0]    res_len_r;
  logic             res_cut_r;

  // hold / send computation
  logic [TB-1:0] amt;
  logic [TB:0]   send_sum;
  always_comb begin
    amt      = (exc_r > TB'(pen_r)) ? exc_r : TB'(pen_r);
    send_sum = {1'b0, now_r} + {1'b0, amt};
  end

  // restoring divider step
  logic [CFG_W:0] rem_sh, rem_diff;
  logic           rem_ge;
  always_comb begin
    rem_sh   = {rem_r, quo_r[LB-1]};
    rem_diff = rem_sh - {1'b0, bpt_r};
    rem_ge   = (rem_sh >= {1'b0, bpt_r});
  end

  // saturating timer adds
  logic [SW-1:0] pen_sum, quo_sum;
  logic [LB-1:0] quo_eff;
  always_comb begin
    quo_eff = (bpt_r == '0) ? '0 : quo_r;
    pen_sum = SW'(base_r) + SW'(pen_r);
    quo_sum = SW'(t_r) + SW'(quo_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r   <= LEAD_LIMIT_RST;
      pen_r    <= MESSAGE_PENALTY_RST;
      bpt_r    <= BYTES_PER_TICK_RST;
      maxlen_r <= MAX_LINE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEAD_LIMIT:      lead_r   <= cfg_data;
        CFG_MESSAGE_PENALTY: pen_r    <= cfg_data;
        CFG_BYTES_PER_TICK:  bpt_r    <= cfg_data;
        CFG_MAX_LINE_LENGTH: maxlen_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      restart_r <= in_req_type;
      now_r     <= in_now_time;
      len_r     <= in_line_length;
      dl_r      <= in_deadline;
    end
    if (cmd.sum) begin
      nl_r <= {1'b0, now_r} + (TB+1)'(lead_r);
      fp_r <= {1'b0, flood_r} + (TB+1)'(pen_r);
    end
    if (cmd.cmp) begin
      hold_r <= (fp_r > nl_r);
      // flood_r - nl_r fits TB bits whenever it is positive
      exc_r  <= ({1'b0, flood_r} > nl_r) ? TB'({1'b0, flood_r} - nl_r) : '0;
    end
    if (cmd.send) begin
      if (!hold_r)          send_r <= now_r;
      else if (send_sum[TB]) send_r <= TOP;
      else                  send_r <= send_sum[TB-1:0];
    end
    if (cmd.check) begin
      drop_r <= (dl_r < send_r);
      base_r <= (flood_r > send_r) ? flood_r : send_r;
      if (CW'(len_r) > CW'(maxlen_r)) begin
        cut_r     <= 1'b1;
        len_cut_r <= (maxlen_r == '0) ? '0 : LB'(CW'(maxlen_r) - CW'(1));
      end else begin
        cut_r     <= 1'b0;
        len_cut_r <= len_r;
      end
    end
    if (cmd.div_init) begin
      quo_r <= len_cut_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[LB-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
    end
    if (cmd.add_pen) begin
      t_r <= (pen_sum[SW-1:TB] != '0) ? TOP : pen_sum[TB-1:0];
    end
    if (cmd.add_quo) begin
      t_r <= (quo_sum[SW-1:TB] != '0) ? TOP : quo_sum[TB-1:0];
    end
  end

  // flood timer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flood_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cmd.res_wr) begin
        res_valid_r <= 1'b1;
        if (restart_r)    flood_r <= now_r;
        else if (!drop_r) flood_r <= t_r;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      priority if (restart_r) begin
        res_act_r  <= ACT_RESTARTED;
        res_send_r <= now_r;
        res_len_r  <= '0;
        res_cut_r  <= 1'b0;
      end else if (drop_r) begin
        res_act_r  <= ACT_DROPPED;
        res_send_r <= send_r;
        res_len_r  <= '0;
        res_cut_r  <= 1'b0;
      end else begin
        res_act_r  <= ACT_SENT;
        res_send_r <= send_r;
        res_len_r  <= len_cut_r;
        res_cut_r  <= cut_r;
      end
    end
  end

  assign sts.restart   = restart_r;
  assign sts.drop      = drop_r;
  assign sts.rate_zero = (bpt_r == '0);
  assign sts.out_free  = !res_valid_r || out_ready;

  assign out_valid         = res_valid_r;
  assign out_action        = res_act_r;
  assign out_send_time     = res_send_r;
  assign out_sent_length   = res_len_r;
  assign out_was_truncated = res_cut_r;

  a_flood_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.res_wr)) |-> $stable(flood_r))
    else $error("flood timer changed outside result write");

  a_send_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_wr && !restart_r) |-> (send_r >= now_r))
    else $error("send time earlier than arrival time");

endmodule
